// File: sv/vtyp_pkg.sv
`timescale 1ns / 1ps

package vtyp_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_ITERS_DEF = 24;
    localparam int TABLE_FRAC       = 24;

    // CORDIC x/y datapath: 32-bit input plus gain growth and rotation headroom
    localparam int DATA_W = 36;
    localparam int COMP_W = 32;
    localparam int DEG_W  = 9;

    localparam logic [DEG_W-1:0] DEG_0   = 9'd0;
    localparam logic [DEG_W-1:0] DEG_90  = 9'd90;
    localparam logic [DEG_W-1:0] DEG_270 = 9'd270;
    localparam logic [DEG_W-1:0] DEG_360 = 9'd360;

    localparam longint ATAN_Q24 [32] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
        14, 7, 4, 2, 1, 0
    };

    localparam longint INV_GAIN_Q24 = 10188014;

    // Q24 to frac fraction bits, round half up
    function automatic longint from_q24(longint v, int frac);
        int s;
        s = TABLE_FRAC - frac;
        if (s == 0)
        begin
            return v;
        end
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint atan_step(int i, int frac);
        return from_q24(ATAN_Q24[i % 32], frac);
    endfunction

endpackage

// File: sv/vtyp_cell.sv
`timescale 1ns / 1ps

module vtyp_cell #(
    parameter int DW        = vtyp_pkg::DATA_W,
    parameter int AW        = vtyp_pkg::FRAC_BITS_DEF + 10,
    parameter int SW        = 1,
    parameter int SHIFT     = 0,
    parameter int FRAC_BITS = vtyp_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] in_x,
    input  logic signed [DW-1:0] in_y,
    input  logic signed [AW-1:0] in_ang,
    input  logic        [SW-1:0] in_side,
    output logic                 out_valid,
    output logic signed [DW-1:0] out_x,
    output logic signed [DW-1:0] out_y,
    output logic signed [AW-1:0] out_ang,
    output logic        [SW-1:0] out_side
);
    import vtyp_pkg::*;

    localparam logic signed [AW-1:0] STEP = AW'(atan_step(SHIFT, FRAC_BITS));

    logic                 valid_reg;
    logic signed [DW-1:0] x_reg, x_next;
    logic signed [DW-1:0] y_reg, y_next;
    logic signed [AW-1:0] ang_reg, ang_next;
    logic        [SW-1:0] side_reg;
    logic signed [DW-1:0] xs, ys;

    always_comb
    begin
        xs = in_x >>> SHIFT;
        ys = in_y >>> SHIFT;
        if (!in_y[DW-1])
        begin
            x_next   = in_x + ys;
            y_next   = in_y - xs;
            ang_next = in_ang + STEP;
        end
        else
        begin
            x_next   = in_x - ys;
            y_next   = in_y + xs;
            ang_next = in_ang - STEP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            ang_reg  <= ang_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_ang   = ang_reg;
    assign out_side  = side_reg;

endmodule

// File: sv/vtyp_gain.sv
`timescale 1ns / 1ps

module vtyp_gain #(
    parameter int DW        = vtyp_pkg::DATA_W,
    parameter int SW        = 1,
    parameter int FRAC_BITS = vtyp_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [DW-1:0] in_x,
    input  logic        [SW-1:0] in_side,
    output logic                 out_valid,
    output logic signed [DW-1:0] out_len,
    output logic        [SW-1:0] out_side
);
    import vtyp_pkg::*;

    localparam int GW = FRAC_BITS + 1;
    localparam int PW = DW + GW;
    localparam logic signed [GW-1:0] GAIN = GW'(from_q24(INV_GAIN_Q24, FRAC_BITS));
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FRAC_BITS - 1);

    logic                 v1_reg, v2_reg;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic        [SW-1:0] side1_reg, side2_reg;
    logic signed [PW-1:0] rnd, shifted;
    logic signed [DW-1:0] len_reg, len_next;

    always_comb
    begin
        prod_next = in_x * GAIN;
        rnd       = prod_reg + HALF;
        shifted   = rnd >>> FRAC_BITS;
        len_next  = shifted[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            side1_reg <= in_side;
            len_reg   <= len_next;
            side2_reg <= side1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_len   = len_reg;
    assign out_side  = side2_reg;

endmodule

// File: sv/vtyp_deg.sv
`timescale 1ns / 1ps

module vtyp_deg #(
    parameter int AW           = vtyp_pkg::FRAC_BITS_DEF + 10,
    parameter int FRAC_BITS    = vtyp_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_ITERS = vtyp_pkg::CORDIC_ITERS_DEF
) (
    input  logic signed [AW-1:0]              ang,
    output logic [vtyp_pkg::DEG_W-1:0]        deg
);
    import vtyp_pkg::*;

    logic          neg;
    logic [AW-1:0] mag;
    logic [AW:0]   sum;
    logic [AW:0]   whole;
    logic [DEG_W-1:0] d;

    // bias by iteration count absorbs residual error
    always_comb
    begin
        neg   = ang[AW-1];
        mag   = neg ? AW'(-ang) : AW'(ang);
        sum   = {1'b0, mag} + (AW+1)'(CORDIC_ITERS);
        whole = sum >> FRAC_BITS;
        d     = whole[DEG_W-1:0];
        if (neg && (d != DEG_0))
        begin
            deg = DEG_360 - d;
        end
        else
        begin
            deg = d;
        end
    end

endmodule

// File: sv/vector_to_yaw_pitch_degrees_core.sv
// Pipeline: input pre-rotation register, yaw CORDIC chain, gain multiply, pitch CORDIC chain, output register.
// Throughput: one vector per cycle while out_stall holds no result; two unrolled chains of CORDIC cells plus
// a two-stage gain multiply, all advancing together.
// A result held under out_stall freezes the whole pipeline and raises in_stall.
// Reset (rst_n, async, active low) clears the stage valid bits only.
`timescale 1ns / 1ps

module vector_to_yaw_pitch_degrees_core #(
    parameter int FRAC_BITS    = vtyp_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_ITERS = vtyp_pkg::CORDIC_ITERS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [vtyp_pkg::COMP_W-1:0]    vec_x,
    input  logic signed [vtyp_pkg::COMP_W-1:0]    vec_y,
    input  logic signed [vtyp_pkg::COMP_W-1:0]    vec_z,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [vtyp_pkg::DEG_W-1:0]            pitch_deg,
    output logic [vtyp_pkg::DEG_W-1:0]            yaw_deg
);
    import vtyp_pkg::*;

    localparam int DW  = DATA_W;
    localparam int AW  = FRAC_BITS + 10;
    localparam int YSW = 2 + COMP_W;
    localparam int GSW = 2 + AW + COMP_W;
    localparam int PSW = 2 + AW;
    localparam logic signed [AW-1:0] ANG_90 = AW'(2 * atan_step(0, FRAC_BITS));

    logic en;

    // input stage: quadrant pre-rotation
    logic                 pv_reg;
    logic signed [DW-1:0] px_reg, px_next;
    logic signed [DW-1:0] py_reg, py_next;
    logic signed [AW-1:0] pa_reg, pa_next;
    logic        [YSW-1:0] ps_reg;
    logic signed [DW-1:0] ex, ey;

    always_comb
    begin
        ex = DW'(vec_x);
        ey = DW'(vec_y);
        if (vec_x[COMP_W-1])
        begin
            if (!vec_y[COMP_W-1])
            begin
                px_next = ey;
                py_next = -ex;
                pa_next = ANG_90;
            end
            else
            begin
                px_next = -ey;
                py_next = ex;
                pa_next = -ANG_90;
            end
        end
        else
        begin
            px_next = ex;
            py_next = ey;
            pa_next = '0;
        end
    end

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else if (en)
        begin
            pv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
            pa_reg <= pa_next;
            ps_reg <= {(vec_x == '0) && (vec_y == '0), vec_z > 0, vec_z};
        end
    end

    // yaw chain
    logic                  yv [0:CORDIC_ITERS];
    logic signed [DW-1:0]  yx [0:CORDIC_ITERS];
    logic signed [DW-1:0]  yy [0:CORDIC_ITERS];
    logic signed [AW-1:0]  ya [0:CORDIC_ITERS];
    logic        [YSW-1:0] ys [0:CORDIC_ITERS];

    assign yv[0] = pv_reg;
    assign yx[0] = px_reg;
    assign yy[0] = py_reg;
    assign ya[0] = pa_reg;
    assign ys[0] = ps_reg;

    for (genvar g = 0; g < CORDIC_ITERS; g++)
    begin : g_yaw
        vtyp_cell #(
            .DW(DW), .AW(AW), .SW(YSW), .SHIFT(g), .FRAC_BITS(FRAC_BITS)
        ) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(yv[g]), .in_x(yx[g]), .in_y(yy[g]), .in_ang(ya[g]),
            .in_side(ys[g]),
            .out_valid(yv[g+1]), .out_x(yx[g+1]), .out_y(yy[g+1]),
            .out_ang(ya[g+1]), .out_side(ys[g+1])
        );
    end

    // gain compensation
    logic                  gv;
    logic signed [DW-1:0]  glen;
    logic        [GSW-1:0] gs;
    logic                  g_unused;

    vtyp_gain #(
        .DW(DW), .SW(GSW), .FRAC_BITS(FRAC_BITS)
    ) u_gain (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(yv[CORDIC_ITERS]), .in_x(yx[CORDIC_ITERS]),
        .in_side({ys[CORDIC_ITERS][YSW-1 -: 2], ya[CORDIC_ITERS],
                  ys[CORDIC_ITERS][COMP_W-1:0]}),
        .out_valid(gv), .out_len(glen), .out_side(gs)
    );

    // final yaw residual is not needed
    assign g_unused = ^yy[CORDIC_ITERS];

    // pitch chain
    logic                  qv [0:CORDIC_ITERS];
    logic signed [DW-1:0]  qx [0:CORDIC_ITERS];
    logic signed [DW-1:0]  qy [0:CORDIC_ITERS];
    logic signed [AW-1:0]  qa [0:CORDIC_ITERS];
    logic        [PSW-1:0] qs [0:CORDIC_ITERS];

    assign qv[0] = gv;
    assign qx[0] = glen;
    assign qy[0] = DW'(signed'(gs[COMP_W-1:0]));
    assign qa[0] = '0;
    assign qs[0] = gs[GSW-1:COMP_W];

    for (genvar g = 0; g < CORDIC_ITERS; g++)
    begin : g_pitch
        vtyp_cell #(
            .DW(DW), .AW(AW), .SW(PSW), .SHIFT(g), .FRAC_BITS(FRAC_BITS)
        ) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(qv[g]), .in_x(qx[g]), .in_y(qy[g]), .in_ang(qa[g]),
            .in_side(qs[g]),
            .out_valid(qv[g+1]), .out_x(qx[g+1]), .out_y(qy[g+1]),
            .out_ang(qa[g+1]), .out_side(qs[g+1])
        );
    end

    // degree conversion and output register
    logic [DEG_W-1:0] pdeg, ydeg;
    logic             sp, zpos;
    logic             ov_reg;
    logic [DEG_W-1:0] pitch_reg, pitch_next;
    logic [DEG_W-1:0] yaw_reg, yaw_next;
    logic             q_unused;

    vtyp_deg #(.AW(AW), .FRAC_BITS(FRAC_BITS), .CORDIC_ITERS(CORDIC_ITERS)) u_pdeg (
        .ang(qa[CORDIC_ITERS]), .deg(pdeg)
    );

    vtyp_deg #(.AW(AW), .FRAC_BITS(FRAC_BITS), .CORDIC_ITERS(CORDIC_ITERS)) u_ydeg (
        .ang(qs[CORDIC_ITERS][AW-1:0]), .deg(ydeg)
    );

    assign q_unused = ^{qx[CORDIC_ITERS], qy[CORDIC_ITERS]};

    always_comb
    begin
        sp   = qs[CORDIC_ITERS][PSW-1];
        zpos = qs[CORDIC_ITERS][PSW-2];
        if (sp)
        begin
            pitch_next = zpos ? DEG_90 : DEG_270;
            yaw_next   = DEG_0;
        end
        else
        begin
            pitch_next = pdeg;
            yaw_next   = ydeg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= qv[CORDIC_ITERS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign out_valid = ov_reg;
    assign pitch_deg = pitch_reg;
    assign yaw_deg   = yaw_reg;

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (yaw_deg < DEG_360))
        else $error("yaw out of range");

    // tiny vectors can overshoot past 90 degrees in the pitch chain
    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_deg < DEG_360))
        else $error("pitch out of range");

    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> (!out_valid && !gv && !pv_reg))
        else $error("valid bits set in reset");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(gv) && $stable(pv_reg)))
        else $error("pipeline moved under stall");

endmodule
